### rtl/mtwm_pkg.sv
package mtwm_pkg;

  localparam int NUM_WHEELS = 4;
  localparam int IDX_W      = 2;
  localparam int IN_W       = 16;
  localparam int SUM_W      = 18;
  localparam int MAG_W      = 17;
  localparam int SCALE_W    = 20;
  localparam int LIM_W      = 16;
  localparam int W_W        = 17;
  localparam int WMAG_W     = 24;
  localparam int PROD_W     = MAG_W + SCALE_W;
  localparam int DIVD_W     = WMAG_W + LIM_W;
  localparam int Q_W        = 16;
  localparam int DIV_STEPS  = Q_W / 2;
  localparam int STEP_W     = $clog2(DIV_STEPS);
  localparam int VEL_SHIFT  = 20;
  localparam int PCT_SHIFT  = 13;

  localparam logic [LIM_W-1:0] PCT_ONE = 16'd32768;

  // drive modes
  localparam logic [1:0] MODE_MECANUM = 2'd0;
  localparam logic [1:0] MODE_TANK    = 2'd1;

  // register indexes
  localparam logic [1:0] CFG_VELOCITY_MODE     = 2'd0;
  localparam logic [1:0] CFG_COUNTS_SCALE      = 2'd1;
  localparam logic [1:0] CFG_MAX_COUNTS        = 2'd2;
  localparam logic [1:0] CFG_INVERSE_MAX_SPEED = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_SCALE,
    ST_DIV,
    ST_STORE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             load_in;
    logic             mul_en;
    logic             keep_all;
    logic             scale_en;
    logic             div_en;
    logic             store_q;
    logic             load_out;
    logic             upd;
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic over;
  } dp_status_t;

endpackage

### rtl/mecanum_tank_wheel_mixer.sv
// Mecanum / tank wheel mixer, one result beat per input beat.
// Without limiting, an item takes four scale multiplies and the limit check; when limiting
// applies, each wheel then takes a limit multiply, 8 radix-4 divide steps and a store.
// Hold modes go straight to the output load. One item in flight; the next item is accepted
// once the current result is loaded. Shared scale and limit multipliers; 2-bit-per-cycle divider.
// rst (synchronous, active high) clears the config registers, held wheels and control.
module mecanum_tank_wheel_mixer import mtwm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [SCALE_W-1:0]     cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [IN_W-1:0] strafe_speed,
  input  logic signed [IN_W-1:0] forward_speed,
  input  logic signed [IN_W-1:0] turn_speed,
  input  logic [1:0]             drive_mode,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [W_W-1:0]  wheel_one,
  output logic signed [W_W-1:0]  wheel_two,
  output logic signed [W_W-1:0]  wheel_three,
  output logic signed [W_W-1:0]  wheel_four,
  output logic                   is_velocity,
  output logic                   updated
);

  // Config writes are registered; the user must only write them while the block is idle (not enforced here).
  assign cfg_ready = 1'b1;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer: accept, four scale multiplies, limit check, optional multiply/divide/store
  // per wheel, then load the output register; hold modes go straight to the load.
  mtwm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .drive_mode (drive_mode),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .cmd        (cmd)
  );

  // Datapath: config registers, wheel sums, shared multipliers, divider,
  // held wheel state and the output register.
  mtwm_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .strafe_speed  (strafe_speed),
    .forward_speed (forward_speed),
    .turn_speed    (turn_speed),
    .drive_mode    (drive_mode),
    .cmd           (cmd),
    .status        (status),
    .wheel_one     (wheel_one),
    .wheel_two     (wheel_two),
    .wheel_three   (wheel_three),
    .wheel_four    (wheel_four),
    .is_velocity   (is_velocity),
    .updated       (updated)
  );

endmodule

### rtl/mtwm_ctrl.sv
module mtwm_ctrl import mtwm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] drive_mode,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t            state, state_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic [STEP_W-1:0] step, step_next;
  logic              upd, upd_next;
  logic              out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      step      <= '0;
      upd       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      step      <= step_next;
      upd       <= upd_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    step_next  = step;
    upd_next   = upd;
    cmd        = '0;
    cmd.idx    = idx;
    cmd.upd    = upd;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          idx_next    = '0;
          if (drive_mode == MODE_MECANUM || drive_mode == MODE_TANK) begin
            upd_next   = 1'b1;
            state_next = ST_MUL;
          end else begin
            upd_next   = 1'b0;
            state_next = ST_DONE;
          end
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        if (idx == IDX_W'(NUM_WHEELS - 1)) begin
          state_next = ST_CHECK;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_CHECK: begin
        idx_next = '0;
        if (status.over) begin
          state_next = ST_SCALE;
        end else begin
          cmd.keep_all = 1'b1;
          state_next   = ST_DONE;
        end
      end
      ST_SCALE: begin
        cmd.scale_en = 1'b1;
        step_next    = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_en = 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = ST_STORE;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_STORE: begin
        cmd.store_q = 1'b1;
        if (idx == IDX_W'(NUM_WHEELS - 1)) begin
          state_next = ST_DONE;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = ST_SCALE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

endmodule

### rtl/mtwm_dp.sv
module mtwm_dp import mtwm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [1:0]             cfg_index,
  input  logic [SCALE_W-1:0]     cfg_data,
  input  logic signed [IN_W-1:0] strafe_speed,
  input  logic signed [IN_W-1:0] forward_speed,
  input  logic signed [IN_W-1:0] turn_speed,
  input  logic [1:0]             drive_mode,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  output logic signed [W_W-1:0]  wheel_one,
  output logic signed [W_W-1:0]  wheel_two,
  output logic signed [W_W-1:0]  wheel_three,
  output logic signed [W_W-1:0]  wheel_four,
  output logic                   is_velocity,
  output logic                   updated
);

  logic               velocity_mode;
  logic [SCALE_W-1:0] counts_scale;
  logic [LIM_W-1:0]   max_counts;
  logic [SCALE_W-1:0] inverse_max_speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      velocity_mode     <= 1'b0;
      counts_scale      <= '0;
      max_counts        <= '0;
      inverse_max_speed <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_VELOCITY_MODE:     velocity_mode     <= cfg_data[0];
        CFG_COUNTS_SCALE:      counts_scale      <= cfg_data;
        CFG_MAX_COUNTS:        max_counts        <= cfg_data[LIM_W-1:0];
        CFG_INVERSE_MAX_SPEED: inverse_max_speed <= cfg_data;
        default: ;
      endcase
    end
  end

  // wheel sums, sign/magnitude
  logic signed [SUM_W-1:0] xs, ys, zs;
  logic signed [SUM_W-1:0] s_new [NUM_WHEELS];
  logic                    mecanum;

  assign xs = SUM_W'(strafe_speed);
  assign ys = SUM_W'(forward_speed);
  assign zs = SUM_W'(turn_speed);
  assign mecanum = (drive_mode == MODE_MECANUM);

  always_comb begin
    if (mecanum) begin
      s_new[0] = xs + ys + zs;
      s_new[1] = ys - xs + zs;
      s_new[2] = ys - xs - zs;
      s_new[3] = xs + ys - zs;
    end else begin
      s_new[0] = ys + zs;
      s_new[1] = ys + zs;
      s_new[2] = ys - zs;
      s_new[3] = ys - zs;
    end
  end

  logic              sneg [NUM_WHEELS];
  logic [MAG_W-1:0]  smag [NUM_WHEELS];
  logic              wneg [NUM_WHEELS];
  logic [WMAG_W-1:0] wmag [NUM_WHEELS];
  logic [WMAG_W-1:0] largest;

  // scale multiply, one wheel a cycle
  logic [SCALE_W-1:0] scale;
  logic [PROD_W-1:0]  prod;
  logic [WMAG_W-1:0]  wm_new;
  logic [LIM_W-1:0]   limit;

  assign scale  = velocity_mode ? counts_scale : inverse_max_speed;
  assign prod   = PROD_W'(smag[cmd.idx]) * PROD_W'(scale);
  assign wm_new = velocity_mode ? WMAG_W'(prod >> VEL_SHIFT) : WMAG_W'(prod >> PCT_SHIFT);
  assign limit  = velocity_mode ? max_counts : PCT_ONE;
  assign status.over = largest > WMAG_W'(limit);

  // limit multiply and radix-4 restoring divide by largest
  logic [DIVD_W-1:0] dvd;
  logic [WMAG_W-1:0] rem;
  logic [Q_W-1:0]    low;
  logic [Q_W-1:0]    quo;
  logic [WMAG_W:0]   t1, t2, dsr;
  logic              b1, b2;
  logic [WMAG_W-1:0] r1, r2;

  assign dvd = DIVD_W'(wmag[cmd.idx]) * DIVD_W'(limit);
  assign dsr = {1'b0, largest};

  always_comb begin
    t1 = {rem, low[Q_W-1]};
    b1 = t1 >= dsr;
    r1 = b1 ? WMAG_W'(t1 - dsr) : WMAG_W'(t1);
    t2 = {r1, low[Q_W-2]};
    b2 = t2 >= dsr;
    r2 = b2 ? WMAG_W'(t2 - dsr) : WMAG_W'(t2);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        sneg[i] <= s_new[i][SUM_W-1];
        smag[i] <= s_new[i][SUM_W-1] ? MAG_W'(-s_new[i]) : MAG_W'(s_new[i]);
      end
      largest <= '0;
    end else if (cmd.mul_en) begin
      wmag[cmd.idx] <= wm_new;
      wneg[cmd.idx] <= sneg[cmd.idx];
      if (wm_new > largest) largest <= wm_new;
    end
    if (cmd.scale_en) begin
      rem <= dvd[DIVD_W-1:Q_W];
      low <= dvd[Q_W-1:0];
      quo <= '0;
    end else if (cmd.div_en) begin
      rem <= r2;
      low <= low << 2;
      quo <= {quo[Q_W-3:0], b1, b2};
    end
  end

  // held wheels, the block state
  logic signed [W_W-1:0] held [NUM_WHEELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WHEELS; i++) held[i] <= '0;
    end else if (cmd.keep_all) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        held[i] <= wneg[i] ? -W_W'(wmag[i]) : W_W'(wmag[i]);
      end
    end else if (cmd.store_q) begin
      held[cmd.idx] <= wneg[cmd.idx] ? -W_W'(quo) : W_W'(quo);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      wheel_one   <= held[0];
      wheel_two   <= held[1];
      wheel_three <= held[2];
      wheel_four  <= held[3];
      is_velocity <= velocity_mode;
      updated     <= cmd.upd;
    end
  end

endmodule
